[rtl/core/spp_pkg.sv]
// ----------------------------------------------------------------------------
// spp_pkg
// Shared widths, codes and types of the segment projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package spp_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned DiffW     = 33;
  localparam int unsigned ProdW     = 66;
  localparam int unsigned NumW      = 66;
  localparam int unsigned QuoW      = 34;
  localparam int unsigned LenW      = 33;
  localparam int unsigned ProgInW   = 34;
  localparam int unsigned LatW      = 34;
  localparam int unsigned MinW      = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned RemW      = 37;

  localparam logic [MinW-1:0] MinLenReset = 16'd66;
  localparam logic [QuoW-1:0] LatNegMax   = 34'h2_0000_0000;
  localparam logic [QuoW-1:0] LatPosMax   = 34'h1_FFFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_END_X       = 3'd2,
    REG_END_Y       = 3'd3,
    REG_START_VALID = 3'd4,
    REG_END_VALID   = 3'd5,
    REG_MIN_LEN     = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_PROJECT     = 1'b0,
    OP_AT_PROGRESS = 1'b1
  } op_e;

  typedef struct packed {
    logic                     busy;
    logic                     ok;
    logic [LenW-1:0]          len;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
  } line_t;

  typedef struct packed {
    logic                      ok;
    logic                      op;
    logic signed [DiffW-1:0]   rx;
    logic signed [DiffW-1:0]   ry;
    logic signed [ProgInW-1:0] pin;
  } item_t;

endpackage

`default_nettype wire

[rtl/core/spp_if.sv]
// ----------------------------------------------------------------------------
// spp_if
// Query and result channels: valid, ready and the word's fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface spp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [spp_pkg::CoordW-1:0]  point_x;
  logic signed [spp_pkg::CoordW-1:0]  point_y;
  logic signed [spp_pkg::ProgInW-1:0] progress_in;
  modport source (output valid, op, point_x, point_y, progress_in, input ready);
  modport sink (input valid, op, point_x, point_y, progress_in, output ready);
endinterface

interface spp_out_if;
  logic                              valid;
  logic                              ready;
  logic                              line_ok;
  logic [spp_pkg::LenW-1:0]          progress_out;
  logic signed [spp_pkg::LatW-1:0]   lateral_error;
  logic signed [spp_pkg::CoordW-1:0] proj_x;
  logic signed [spp_pkg::CoordW-1:0] proj_y;
  modport source (output valid, line_ok, progress_out, lateral_error, proj_x, proj_y,
                  input ready);
  modport sink (input valid, line_ok, progress_out, lateral_error, proj_x, proj_y,
                output ready);
endinterface

`default_nettype wire

[rtl/core/segment_projection_progress_core.sv]
// ----------------------------------------------------------------------------
// segment_projection_progress_core
// Projects points onto a configured line, or places a point at a given
// progress, giving clamped progress, lateral error and the point on the line.
//
// Query words enter on in_i and results leave on out_o, one result per query,
// in order. The user must write line registers through cfg_we_i/cfg_idx_i/
// cfg_wdata_i only while no query is in flight; the core does not enforce it.
// Each write restarts the length unit: in_i.ready drops while the direction
// is formed, squared and summed and the 33-step bit-pair square root runs.
// With the output taken every cycle and no length run under way the core
// accepts one query per cycle; each result passes the queue, product and sum
// stages, two 35-stage dividers, clamp and scale stages and result register.
// When out_o.ready is low with a result waiting, the whole back pipeline
// holds, the queue between front and back fills and in_i.ready then drops.
// Reset clears the line to zero with both valid flags low and the minimum
// length at 66, so every result reads all zeros until a usable line is written.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_projection_progress_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [spp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [spp_pkg::CfgDataW-1:0] cfg_wdata_i,
  spp_in_if.sink                            in_i,
  spp_out_if.source                         out_o
);

  spp_pkg::line_t line;
  spp_pkg::item_t fr_item, q_item;
  logic           push, full, pop, empty;

  spp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .line_o      (line)
  );

  spp_front u_front (
    .in_i   (in_i),
    .line_i (line),
    .full_i (full),
    .push_o (push),
    .item_o (fr_item)
  );

  spp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (q_item)
  );

  spp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (q_item),
    .pop_o   (pop),
    .line_i  (line),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

[rtl/core/spp_cfg.sv]
// ----------------------------------------------------------------------------
// spp_cfg
// Line registers; works out direction, length (bit-pair square root) and
// usability after every register write.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [spp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [spp_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output spp_pkg::line_t                        line_o
);

  localparam int unsigned CntW = $clog2(spp_pkg::SqrtSteps);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_SUM, ST_ROOT
  } state_e;

  state_e                              state_q;
  logic signed [spp_pkg::CoordW-1:0]   sx_q, sy_q, ex_q, ey_q;
  logic                                sv_q, ev_q;
  logic [spp_pkg::MinW-1:0]            min_q;
  logic signed [spp_pkg::DiffW-1:0]    dx_q, dy_q;
  logic [spp_pkg::ProdW-1:0]           sqa_q, sqb_q;
  logic [spp_pkg::NumW-1:0]            rad_q;
  logic [spp_pkg::RemW-1:0]            rem_q;
  logic [spp_pkg::LenW-1:0]            root_q, len_q;
  logic [CntW-1:0]                     cnt_q;

  logic [spp_pkg::DiffW-1:0]           mx, my;
  logic [spp_pkg::RemW-1:0]            rem_x, trial;
  logic                                ge;
  logic [spp_pkg::LenW-1:0]            root_d;

  assign mx     = dx_q[spp_pkg::DiffW-1] ? spp_pkg::DiffW'(-dx_q) : dx_q;
  assign my     = dy_q[spp_pkg::DiffW-1] ? spp_pkg::DiffW'(-dy_q) : dy_q;
  assign rem_x  = {rem_q[spp_pkg::RemW-3:0], rad_q[spp_pkg::NumW-1 -: 2]};
  assign trial  = spp_pkg::RemW'({root_q, 2'b01});
  assign ge     = rem_x >= trial;
  assign root_d = {root_q[spp_pkg::LenW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sx_q    <= '0;
      sy_q    <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      sv_q    <= 1'b0;
      ev_q    <= 1'b0;
      min_q   <= spp_pkg::MinLenReset;
      dx_q    <= '0;
      dy_q    <= '0;
      sqa_q   <= '0;
      sqb_q   <= '0;
      rad_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      state_q <= ST_DIFF;
      case (spp_pkg::cfg_reg_e'(cfg_idx_i))
        spp_pkg::REG_START_X:     sx_q  <= cfg_wdata_i;
        spp_pkg::REG_START_Y:     sy_q  <= cfg_wdata_i;
        spp_pkg::REG_END_X:       ex_q  <= cfg_wdata_i;
        spp_pkg::REG_END_Y:       ey_q  <= cfg_wdata_i;
        spp_pkg::REG_START_VALID: sv_q  <= cfg_wdata_i[0];
        spp_pkg::REG_END_VALID:   ev_q  <= cfg_wdata_i[0];
        spp_pkg::REG_MIN_LEN:     min_q <= cfg_wdata_i[spp_pkg::MinW-1:0];
        default: ;
      endcase
    end else begin
      unique case (state_q)
        ST_IDLE: ;
        ST_DIFF: begin
          dx_q    <= {ex_q[spp_pkg::CoordW-1], ex_q} - {sx_q[spp_pkg::CoordW-1], sx_q};
          dy_q    <= {ey_q[spp_pkg::CoordW-1], ey_q} - {sy_q[spp_pkg::CoordW-1], sy_q};
          state_q <= ST_SQX;
        end
        ST_SQX: begin
          sqa_q   <= mx * mx;
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          sqb_q   <= my * my;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          rad_q   <= sqa_q + sqb_q;
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= CntW'(spp_pkg::SqrtSteps - 1);
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          rem_q  <= ge ? rem_x - trial : rem_x;
          root_q <= root_d;
          rad_q  <= rad_q << 2;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            len_q   <= root_d;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign line_o.busy = state_q != ST_IDLE;
  assign line_o.ok   = sv_q && ev_q && (len_q != '0) && (len_q >= spp_pkg::LenW'(min_q));
  assign line_o.len  = len_q;
  assign line_o.sx   = sx_q;
  assign line_o.sy   = sy_q;
  assign line_o.dx   = dx_q;
  assign line_o.dy   = dy_q;

endmodule

`default_nettype wire

[rtl/core/spp_front.sv]
// ----------------------------------------------------------------------------
// spp_front
// Accepts queries, offsets the point from the line start and tags the word
// with its op and the line's usability.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_front (
  spp_in_if.sink                  in_i,
  input  spp_pkg::line_t          line_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output spp_pkg::item_t          item_o
);

  assign in_i.ready = !line_i.busy && !full_i;
  assign push_o     = in_i.valid && in_i.ready;

  assign item_o.ok  = line_i.ok;
  assign item_o.op  = in_i.op;
  assign item_o.rx  = {in_i.point_x[spp_pkg::CoordW-1], in_i.point_x}
                    - {line_i.sx[spp_pkg::CoordW-1], line_i.sx};
  assign item_o.ry  = {in_i.point_y[spp_pkg::CoordW-1], in_i.point_y}
                    - {line_i.sy[spp_pkg::CoordW-1], line_i.sy};
  assign item_o.pin = in_i.progress_in;

endmodule

`default_nettype wire

[rtl/core/spp_fifo.sv]
// ----------------------------------------------------------------------------
// spp_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  spp_pkg::item_t     item_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output spp_pkg::item_t     item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  spp_pkg::item_t    mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/spp_div.sv]
// ----------------------------------------------------------------------------
// spp_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag when the quotient does not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_div (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [spp_pkg::NumW-1:0]   num_i,
  input  wire logic [spp_pkg::LenW-1:0]   den_i,
  output logic [spp_pkg::QuoW-1:0]        quo_o,
  output logic                            ovf_o
);

  localparam int unsigned QW = spp_pkg::QuoW;
  localparam int unsigned LW = spp_pkg::LenW;

  logic [LW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= LW'(num_i[spp_pkg::NumW-1:QW]);
      low_q[0] <= num_i[QW-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= LW'(num_i[spp_pkg::NumW-1:QW]) >= den_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [LW:0] sh;
    logic        ge;
    assign sh = {rem_q[k-1], low_q[k-1][QW-1]};
    assign ge = sh >= {1'b0, den_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
    if (k < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? LW'(sh - {1'b0, den_i}) : sh[LW-1:0];
          low_q[k] <= low_q[k-1] << 1;
        end
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

`default_nettype wire

[rtl/core/spp_back.sv]
// ----------------------------------------------------------------------------
// spp_back
// Products, dot and cross, divide by length, clamp, scale the direction and
// divide again; ends in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  spp_pkg::item_t     item_i,
  output logic               pop_o,
  input  spp_pkg::line_t     line_i,
  spp_out_if.source          out_o
);

  localparam int unsigned DivLat = spp_pkg::QuoW + 1;
  localparam int unsigned NStage = 2 * DivLat + 5;
  localparam int unsigned PW     = spp_pkg::ProdW;
  localparam int unsigned LW     = spp_pkg::LenW;
  localparam int unsigned QW     = spp_pkg::QuoW;

  typedef struct packed {
    logic                              ok;
    logic                              op;
    logic                              dneg;
    logic                              cneg;
    logic signed [spp_pkg::ProgInW-1:0] pin;
  } sb1_t;

  typedef struct packed {
    logic                            ok;
    logic [LW-1:0]                   prog;
    logic signed [spp_pkg::LatW-1:0] lat;
  } sb2_t;

  logic [NStage-1:0] vld_q;
  logic              en;

  assign en    = !vld_q[NStage-1] || out_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStage-2:0], pop_o};
    end
  end

  logic signed [PW-1:0]               p1_q, p2_q, p3_q, p4_q;
  logic                               s1_ok_q, s1_op_q;
  logic signed [spp_pkg::ProgInW-1:0] s1_pin_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q     <= $signed(item_i.rx) * $signed(line_i.dx);
      p2_q     <= $signed(item_i.ry) * $signed(line_i.dy);
      p3_q     <= $signed(item_i.ry) * $signed(line_i.dx);
      p4_q     <= $signed(item_i.rx) * $signed(line_i.dy);
      s1_ok_q  <= item_i.ok;
      s1_op_q  <= item_i.op;
      s1_pin_q <= item_i.pin;
    end
  end

  logic [PW:0]                dot, crs;
  logic [spp_pkg::NumW-1:0]   dmag_q, cmag_q;
  sb1_t                       sb1_q [DivLat+1];

  assign dot = {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q};
  assign crs = {p3_q[PW-1], p3_q} - {p4_q[PW-1], p4_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag_q         <= spp_pkg::NumW'(dot[PW] ? (~dot + 1'b1) : dot);
      cmag_q         <= spp_pkg::NumW'(crs[PW] ? (~crs + 1'b1) : crs);
      sb1_q[0].ok    <= s1_ok_q;
      sb1_q[0].op    <= s1_op_q;
      sb1_q[0].dneg  <= dot[PW];
      sb1_q[0].cneg  <= crs[PW];
      sb1_q[0].pin   <= s1_pin_q;
      for (int k = 1; k <= DivLat; k++) begin
        sb1_q[k] <= sb1_q[k-1];
      end
    end
  end

  logic [QW-1:0] qd, qc;
  logic          ovd, ovc;

  spp_div u_div_dot (
    .clk_i (clk_i), .en_i (en), .num_i (dmag_q), .den_i (line_i.len),
    .quo_o (qd), .ovf_o (ovd)
  );

  spp_div u_div_crs (
    .clk_i (clk_i), .en_i (en), .num_i (cmag_q), .den_i (line_i.len),
    .quo_o (qc), .ovf_o (ovc)
  );

  sb1_t                            sb1;
  logic [LW-1:0]                   prog;
  logic signed [spp_pkg::LatW-1:0] lat;

  assign sb1 = sb1_q[DivLat];

  always_comb begin
    prog = '0;
    lat  = '0;
    if (sb1.op == spp_pkg::OP_PROJECT) begin
      if (!sb1.dneg) begin
        prog = (ovd || qd > QW'(line_i.len)) ? line_i.len : qd[LW-1:0];
      end
      if (sb1.cneg) begin
        lat = -$signed((ovc || qc > spp_pkg::LatNegMax) ? spp_pkg::LatNegMax : qc);
      end else begin
        lat = (ovc || qc > spp_pkg::LatPosMax) ? spp_pkg::LatPosMax : qc;
      end
    end else if (!sb1.pin[spp_pkg::ProgInW-1]) begin
      prog = ($unsigned(sb1.pin) > QW'(line_i.len)) ? line_i.len : sb1.pin[LW-1:0];
    end
  end

  sb2_t                       s3_q;
  sb2_t                       sb2_q [DivLat+1];
  logic [spp_pkg::NumW-1:0]   mx_q, my_q;
  logic [spp_pkg::DiffW-1:0]  adx, ady;

  assign adx = line_i.dx[spp_pkg::DiffW-1] ? spp_pkg::DiffW'(-line_i.dx) : line_i.dx;
  assign ady = line_i.dy[spp_pkg::DiffW-1] ? spp_pkg::DiffW'(-line_i.dy) : line_i.dy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q.ok   <= sb1.ok;
      s3_q.prog <= prog;
      s3_q.lat  <= lat;
      mx_q      <= adx * s3_q.prog;
      my_q      <= ady * s3_q.prog;
      sb2_q[0]  <= s3_q;
      for (int k = 1; k <= DivLat; k++) begin
        sb2_q[k] <= sb2_q[k-1];
      end
    end
  end

  logic [QW-1:0] qx, qy;
  logic          ovx, ovy;

  spp_div u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i (mx_q), .den_i (line_i.len),
    .quo_o (qx), .ovf_o (ovx)
  );

  spp_div u_div_y (
    .clk_i (clk_i), .en_i (en), .num_i (my_q), .den_i (line_i.len),
    .quo_o (qy), .ovf_o (ovy)
  );

  sb2_t                              sb2;
  logic [spp_pkg::CoordW-1:0]        ox, oy;
  logic                              line_ok_q;
  logic [LW-1:0]                     prog_q;
  logic signed [spp_pkg::LatW-1:0]   lat_q;
  logic signed [spp_pkg::CoordW-1:0] px_q, py_q;

  assign sb2 = sb2_q[DivLat];
  assign ox  = line_i.dx[spp_pkg::DiffW-1] ? line_i.sx - qx[spp_pkg::CoordW-1:0]
                                           : line_i.sx + qx[spp_pkg::CoordW-1:0];
  assign oy  = line_i.dy[spp_pkg::DiffW-1] ? line_i.sy - qy[spp_pkg::CoordW-1:0]
                                           : line_i.sy + qy[spp_pkg::CoordW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      line_ok_q <= sb2.ok;
      prog_q    <= sb2.ok ? sb2.prog : '0;
      lat_q     <= sb2.ok ? sb2.lat : '0;
      px_q      <= (sb2.ok && !ovx) ? ox : '0;
      py_q      <= (sb2.ok && !ovy) ? oy : '0;
    end
  end

  assign out_o.valid         = vld_q[NStage-1];
  assign out_o.line_ok       = line_ok_q;
  assign out_o.progress_out  = prog_q;
  assign out_o.lateral_error = lat_q;
  assign out_o.proj_x        = px_q;
  assign out_o.proj_y        = py_q;

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_projection_progress_core: writes line
// settings through the register port, sends projection and progress queries,
// predicts each result in place and checks it field by field, in order,
// with random source gaps and random and forced output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 3000;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned BlockItems = 35;

  typedef struct packed {
    logic                       ok;
    logic [spp_pkg::LenW-1:0]   prog;
    logic [spp_pkg::LatW-1:0]   lat;
    logic [spp_pkg::CoordW-1:0] px;
    logic [spp_pkg::CoordW-1:0] py;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [spp_pkg::CfgIdxW-1:0] cfg_idx;
  logic [spp_pkg::CfgDataW-1:0] cfg_wdata;

  spp_in_if  in_if ();
  spp_out_if out_if ();

  segment_projection_progress_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  logic [31:0] ln_sx, ln_sy, ln_ex, ln_ey;
  logic        ln_sv, ln_ev;
  logic [15:0] ln_min;

  answer_t answers_q[$];
  int unsigned src_idle, snk_idle;
  int unsigned hold_cnt;
  int unsigned watch_cnt;
  int unsigned n_sent, n_checked, n_err, n_ok_lines;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [33:0] isqrt68(input logic [67:0] n);
    logic [67:0] res;
    logic [67:0] t;
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      t = res | (68'd1 << b);
      if (t * t <= n) res = t;
    end
    return res[33:0];
  endfunction

  function automatic logic [31:0] walk(input logic [31:0] s, input logic signed [32:0] d,
                                       input logic [33:0] p, input logic [33:0] len);
    logic [67:0] dm;
    logic [67:0] q;
    dm = d[32] ? 68'(-d) : 68'(d);
    q  = (dm * p) / len;
    return d[32] ? s - q[31:0] : s + q[31:0];
  endfunction

  function automatic answer_t project(input spp_pkg::op_e op, input logic [31:0] x,
                                      input logic [31:0] y, input logic [33:0] pin);
    logic signed [32:0] dx, dy, rx, ry;
    logic [67:0] sq;
    logic [33:0] len, prog;
    logic signed [67:0] dot, crs;
    logic [67:0] dm, cm, q, lq;
    logic [33:0] lat;
    answer_t a;
    a  = '0;
    dx = {ln_ex[31], ln_ex} - {ln_sx[31], ln_sx};
    dy = {ln_ey[31], ln_ey} - {ln_sy[31], ln_sy};
    sq = dx * dx + dy * dy;
    len = isqrt68(sq);
    if (!ln_sv || !ln_ev || len == 0 || len < {18'd0, ln_min}) return a;
    lat = '0;
    if (op == spp_pkg::OP_PROJECT) begin
      rx  = {x[31], x} - {ln_sx[31], ln_sx};
      ry  = {y[31], y} - {ln_sy[31], ln_sy};
      dot = rx * dx + ry * dy;
      crs = ry * dx - rx * dy;
      dm  = dot < 0 ? -dot : dot;
      cm  = crs < 0 ? -crs : crs;
      q   = dm / len;
      lq  = cm / len;
      prog = dot < 0 ? 34'd0 : (q > len ? len : q[33:0]);
      if (crs < 0) begin
        if (lq > 68'h2_0000_0000) lq = 68'h2_0000_0000;
        lat = -lq[33:0];
      end else begin
        if (lq > 68'h1_FFFF_FFFF) lq = 68'h1_FFFF_FFFF;
        lat = lq[33:0];
      end
    end else begin
      prog = pin[33] ? 34'd0 : (pin > len ? len : pin);
    end
    a.ok   = 1'b1;
    a.prog = prog[32:0];
    a.lat  = lat;
    a.px   = walk(ln_sx, dx, prog, len);
    a.py   = walk(ln_sy, dy, prog, len);
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_a, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.line_ok, out_if.progress_out, out_if.lateral_error,
             out_if.proj_x, out_if.proj_y};
      if (answers_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result word %h", $time, got);
      end else begin
        exp_a = answers_q.pop_front();
        n_checked++;
        if (exp_a != got) begin
          n_err++;
          if (n_err < 40) begin
            if (exp_a.ok != got.ok)
              $display("%0t: line_ok exp %0d got %0d", $time, exp_a.ok, got.ok);
            if (exp_a.prog != got.prog)
              $display("%0t: progress exp %h got %h", $time, exp_a.prog, got.prog);
            if (exp_a.lat != got.lat)
              $display("%0t: lateral exp %h got %h", $time, exp_a.lat, got.lat);
            if (exp_a.px != got.px)
              $display("%0t: proj_x exp %h got %h", $time, exp_a.px, got.px);
            if (exp_a.py != got.py)
              $display("%0t: proj_y exp %h got %h", $time, exp_a.py, got.py);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      watch_cnt <= 0;
    end else begin
      watch_cnt <= watch_cnt + 1;
      if (watch_cnt > WatchLimit) begin
        $display("%0t: no progress on either channel", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_word(input spp_pkg::op_e op, input logic [31:0] x, input logic [31:0] y,
                           input logic [33:0] pin);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.point_x     <= x;
    in_if.point_y     <= y;
    in_if.progress_in <= pin;
    do @(posedge clk_i); while (!in_if.ready);
    answers_q.push_back(project(op, x, y, pin));
    n_sent++;
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input spp_pkg::cfg_reg_e idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      spp_pkg::REG_START_X:     ln_sx = v;
      spp_pkg::REG_START_Y:     ln_sy = v;
      spp_pkg::REG_END_X:       ln_ex = v;
      spp_pkg::REG_END_Y:       ln_ey = v;
      spp_pkg::REG_START_VALID: ln_sv = v[0];
      spp_pkg::REG_END_VALID:   ln_ev = v[0];
      spp_pkg::REG_MIN_LEN:     ln_min = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_line(input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] ex,
                          input logic [31:0] ey, input logic sv, input logic ev,
                          input logic [15:0] mn);
    drain();
    set_reg(spp_pkg::REG_START_X, sx);
    set_reg(spp_pkg::REG_START_Y, sy);
    set_reg(spp_pkg::REG_END_X, ex);
    set_reg(spp_pkg::REG_END_Y, ey);
    set_reg(spp_pkg::REG_START_VALID, {31'd0, sv});
    set_reg(spp_pkg::REG_END_VALID, {31'd0, ev});
    set_reg(spp_pkg::REG_MIN_LEN, {16'd0, mn});
    if (sv && ev) n_ok_lines++;
  endtask

  task automatic test_reset_state;
    send_word(spp_pkg::OP_PROJECT, 32'h0001_0000, 32'hFFFF_0000, 34'd0);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'd1000);
  endtask

  task automatic test_directed;
    set_line(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'h0005_0000, 1'b1, 1'b1, 16'd66);
    send_word(spp_pkg::OP_PROJECT, 32'h0003_0000, 32'h0003_8000, 34'd0);
    send_word(spp_pkg::OP_PROJECT, 32'h0000_0000, 32'h0009_0000, 34'h3_FFFF_FFFF);
    send_word(spp_pkg::OP_PROJECT, 32'h0009_0000, 32'h0000_0000, 34'd0);
    send_word(spp_pkg::OP_PROJECT, 32'hFFF0_0000, 32'hFFF0_0000, 34'd0);
    send_word(spp_pkg::OP_PROJECT, 32'h0010_0000, 32'h0010_0000, 34'd0);
    send_word(spp_pkg::OP_PROJECT, 32'h8000_0000, 32'h7FFF_FFFF, 34'd0);
    send_word(spp_pkg::OP_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 34'd0);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 34'h2_0000_0000);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'h1_FFFF_FFFF);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'd0);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'h0_0002_8000);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'h0_0005_0000);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'h0_0005_0001);
    set_line(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
    send_word(spp_pkg::OP_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 34'd0);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'h1_FFFF_FFFF);
    set_line(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0);
    send_word(spp_pkg::OP_PROJECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 34'd0);
    send_word(spp_pkg::OP_PROJECT, 32'h8000_0000, 32'h8000_0000, 34'd0);
    set_line(32'h0123_4567, 32'h89AB_CDEF, 32'h0123_4567, 32'h89AB_CDEF, 1'b1, 1'b1, 16'd0);
    send_word(spp_pkg::OP_PROJECT, 32'h0000_1000, 32'h0000_2000, 34'd5);
    set_line(32'd0, 32'd0, 32'd100, 32'd0, 1'b1, 1'b1, 16'd100);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'd50);
    drain();
    set_reg(spp_pkg::REG_MIN_LEN, 32'd101);
    send_word(spp_pkg::OP_AT_PROGRESS, 32'd0, 32'd0, 34'd50);
    set_line(32'd0, 32'd0, 32'h0010_0000, 32'd0, 1'b1, 1'b0, 16'd66);
    send_word(spp_pkg::OP_PROJECT, 32'h0001_0000, 32'h0001_0000, 34'd0);
    drain();
    set_reg(spp_pkg::REG_START_VALID, 32'd0);
    set_reg(spp_pkg::REG_END_VALID, 32'd1);
    send_word(spp_pkg::OP_PROJECT, 32'h0001_0000, 32'h0001_0000, 34'd0);
  endtask

  task automatic random_line;
    logic [31:0] sx, sy, ex, ey;
    logic [15:0] mn;
    int unsigned kind;
    sx   = $urandom;
    sy   = $urandom;
    kind = $urandom_range(3);
    if (kind == 0) begin
      ex = $urandom;
      ey = $urandom;
    end else if (kind == 3) begin
      ex = sx + $urandom_range(6) - 3;
      ey = sy + $urandom_range(6) - 3;
    end else begin
      ex = sx + ($urandom >> $urandom_range(31, 8)) - ($urandom >> $urandom_range(31, 8));
      ey = sy + ($urandom >> $urandom_range(31, 8)) - ($urandom >> $urandom_range(31, 8));
    end
    case ($urandom_range(3))
      0: mn = 16'd0;
      1: mn = 16'hFFFF;
      2: mn = 16'd66;
      default: mn = 16'($urandom);
    endcase
    if (kind == 3 && $urandom_range(1)) mn = 16'd0;
    set_line(sx, sy, ex, ey, $urandom_range(9) != 0, $urandom_range(9) != 0, mn);
  endtask

  task automatic random_word;
    logic [31:0] x, y;
    logic [33:0] p;
    if ($urandom_range(1)) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = ln_sx + ($urandom >> $urandom_range(31, 4)) - ($urandom >> $urandom_range(31, 4));
      y = ln_sy + ($urandom >> $urandom_range(31, 4)) - ($urandom >> $urandom_range(31, 4));
    end
    p = $urandom_range(1) ? {2'($urandom_range(3)), $urandom}
                          : 34'($urandom >> $urandom_range(31));
    send_word(spp_pkg::op_e'($urandom_range(1)), x, y, p);
  endtask

  task automatic test_random;
    for (int mode = 0; mode < 3; mode++) begin
      src_idle = (mode == 0) ? 17 : (mode == 1) ? 76 : 0;
      snk_idle = (mode == 0) ? 76 : (mode == 1) ? 17 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        random_line();
        if (mode == 2 && blk == 1) hold_cnt <= HoldLen;
        repeat (BlockItems) random_word();
      end
    end
    src_idle = 0;
    snk_idle = 0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.op          = spp_pkg::OP_PROJECT;
    in_if.point_x     = '0;
    in_if.point_y     = '0;
    in_if.progress_in = '0;
    hold_cnt          = 0;
    src_idle          = 17;
    snk_idle          = 76;
    {n_sent, n_checked, n_err, n_ok_lines} = '0;
    {ln_sx, ln_sy, ln_ex, ln_ey} = '0;
    {ln_sv, ln_ev} = 2'b00;
    ln_min = spp_pkg::MinLenReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d queries, checked %0d results over %0d line settings with both flags set",
             n_sent, n_checked, n_ok_lines);
    $display("Covered projection, clamped progress, short and unusable lines, stalls");
    if (n_err == 0 && answers_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
